/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, skipped while reset is asserted.
`define MT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define MT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/mt_pkg.sv */
`timescale 1ns / 1ps

package mt_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 10;

  localparam logic [IDX_W-1:0]  MT_WORDS    = 10'd624;
  localparam logic [IDX_W-1:0]  MT_OFFSET   = 10'd397;
  localparam logic [IDX_W-1:0]  MT_BACK     = 10'd227;  // words - offset
  localparam logic [IDX_W-1:0]  MT_LAST     = 10'd623;
  localparam logic [WORD_W-1:0] MT_MATRIX   = 32'h9908B0DF;
  localparam logic [WORD_W-1:0] MT_UPPER    = 32'h80000000;
  localparam logic [WORD_W-1:0] MT_LOWER    = 32'h7FFFFFFF;
  localparam logic [WORD_W-1:0] MT_TEMPER_B = 32'h9D2C5680;
  localparam logic [WORD_W-1:0] MT_TEMPER_C = 32'hEFC60000;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_NEXT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } mt_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
  } mt_rd_t;

  function automatic logic [IDX_W-1:0] pos_inc(input logic [IDX_W-1:0] p);
    pos_inc = (p == MT_LAST) ? '0 : IDX_W'(p + 10'd1);
  endfunction

  function automatic logic [IDX_W-1:0] pos_far(input logic [IDX_W-1:0] p);
    pos_far = (p >= MT_BACK) ? IDX_W'(p - MT_BACK) : IDX_W'(p + MT_OFFSET);
  endfunction

  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] cur,
                                               input logic [WORD_W-1:0] nxt);
    logic [WORD_W-1:0] mix;
    mix   = (cur & MT_UPPER) | (nxt & MT_LOWER);
    twist = (mix >> 1) ^ (nxt[0] ? MT_MATRIX : '0);
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    temper = y;
  endfunction

endpackage

/* rtl/mt_store.sv */
`timescale 1ns / 1ps

// 624 x 32 state store: one write port, two registered read ports.
module mt_store
  import mt_pkg::*;
(
  input  logic              clk,
  input  mt_wr_t            wr,
  input  mt_rd_t            rd,
  output logic [WORD_W-1:0] rdata_a,
  output logic [WORD_W-1:0] rdata_b
);

  logic [WORD_W-1:0] mem [MT_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds until the next enabled read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata_a <= mem[rd.addr_a];
      rdata_b <= mem[rd.addr_b];
    end
  end

endmodule

/* rtl/mt19937_word_stream_core.sv */
`timescale 1ns / 1ps

// MT19937 word stream core (n = 624, m = 397).
// Input channel in_valid/in_ready carries in_cmd, in_seed_index, in_seed_value.
// A load (in_cmd = 0) writes in_seed_value to word in_seed_index (ignored above
// 623) and returns the position to 0; it produces no output transfer.
// A next (in_cmd = 1) produces one out_random_value transfer on out_valid/out_ready:
// the tempered word at the position, after which that word is twisted in place.
// A next is registered in the twist stage, then its tempered word in the output register.
// Throughput: one next per cycle sustained (out_ready high), set by the 2-read/1-write state store
// (x[p+1] and x[p+397] read per item, x[p] carried over from the prior item).
// A load waits for the one next that may still be in the twist stage.
// The store is not cleared: all 624 words must be loaded before the first next.
// Reset (rst_n low, synchronous) sets the position to 0 and empties the pipeline.
// When out_ready is low the result is held in the output register; one more next
// is still taken into the twist stage, after which in_ready drops for nexts.
module mt19937_word_stream_core
  import mt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [IDX_W-1:0]  in_seed_index,
  input  logic [WORD_W-1:0] in_seed_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_random_value
);

  `include "assert_macros.svh"

  logic [IDX_W-1:0]  pos_r;
  logic              s1_valid_r;
  logic [IDX_W-1:0]  s1_pos_r;
  logic [WORD_W-1:0] s1_cur_r;
  logic [WORD_W-1:0] cur_r;   // x[pos] when the twist stage is empty
  logic [WORD_W-1:0] x0_r;    // shadow copy of x[0]
  logic              out_valid_r;
  logic [WORD_W-1:0] out_value_r;

  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;
  logic [WORD_W-1:0] cur_eff;
  logic [WORD_W-1:0] new_word;
  logic              is_load;
  logic              s1_fire;
  logic              load_acc;
  logic              next_acc;
  mt_wr_t            wr;
  mt_rd_t            rd;

  assign is_load  = (cmd_t'(in_cmd) == CMD_LOAD);
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  // loads share the write port with the twist stage
  assign in_ready = is_load ? !s1_valid_r : (!s1_valid_r || s1_fire);
  assign load_acc = in_valid && in_ready && is_load;
  assign next_acc = in_valid && in_ready && !is_load;

  // x[pos] was read as "next word" by the item in the twist stage
  assign cur_eff  = s1_valid_r ? rdata_a : cur_r;
  assign new_word = rdata_b ^ twist(s1_cur_r, rdata_a);

  always_comb begin
    if (load_acc) begin
      wr.en   = (in_seed_index < MT_WORDS);
      wr.addr = in_seed_index;
      wr.data = in_seed_value;
    end else begin
      wr.en   = s1_fire;
      wr.addr = s1_pos_r;
      wr.data = new_word;
    end
  end

  always_comb begin
    rd.en     = next_acc;
    rd.addr_a = pos_inc(pos_r);
    rd.addr_b = pos_far(pos_r);
  end

  mt_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_acc) begin
        pos_r <= '0;
      end else if (next_acc) begin
        pos_r <= pos_inc(pos_r);
      end

      if (next_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.addr == '0) begin
      x0_r <= wr.data;
    end

    if (load_acc) begin
      cur_r <= (in_seed_index == '0) ? in_seed_value : x0_r;
    end else if (s1_fire) begin
      cur_r <= rdata_a;
    end

    if (next_acc) begin
      s1_pos_r <= pos_r;
      s1_cur_r <= cur_eff;
    end

    if (s1_fire) begin
      out_value_r <= temper(s1_cur_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

  `MT_ASSERT(a_pos_range, pos_r < MT_WORDS, "position out of range")
  `MT_ASSERT(a_load_port_free, load_acc |-> !s1_valid_r, "load collides with twist write")
  `MT_ASSERT(a_load_rewinds, load_acc |=> pos_r == '0, "load did not rewind position")
  `MT_ASSERT(a_s1_hold, s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_pos_r),
             "stalled twist stage lost its item")
  `MT_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> pos_r == '0 && !s1_valid_r && !out_valid_r,
                    "reset did not clear control state")

endmodule
